@@ rtl/tsa_pkg.sv @@
// Shared types and constants for the Taylor series arithmetic block.
// No dependencies.
`default_nettype none
package tsa_pkg;
   localparam int unsigned COEF_W  = 32;
   localparam int unsigned INDEX_W = 5;

   typedef enum logic [2:0] {
      OP_ADD  = 3'd0,
      OP_SUB  = 3'd1,
      OP_MUL  = 3'd2,
      OP_DIV  = 3'd3,
      OP_SCL  = 3'd4,
      OP_ADDS = 3'd5,
      OP_BAD6 = 3'd6,
      OP_BAD7 = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      ST_OK  = 2'd0,
      ST_SAT = 2'd1,
      ST_DIVZ = 2'd2,
      ST_RSVD = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE, S_LOAD, S_MAC, S_DIV, S_FINISH, S_OUT
   } state_type;

   // channel payloads
   typedef struct packed {
      op_type             action;
      logic signed [31:0] u_coef;
      logic signed [31:0] v_coef;
      logic signed [31:0] scalar;
   } req_type;

   typedef struct packed {
      logic signed [31:0]  r_coef;
      logic [INDEX_W-1:0]  term_index;
      logic                last;
      logic [1:0]          status;
   } rsp_type;

   typedef struct packed {
      logic [INDEX_W-1:0] degree;
   } csr_type;

   // controller to datapath
   typedef struct packed {
      logic load;      // take item, write stores
      logic mac_start; // load accumulator (zero, or u for divide), k = 0
      logic mac_step;  // one product term
      logic div_start;
      logic div_step;
      logic finish;    // form result word
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic mac_done;
      logic div_done;
      logic need_mac;
      logic need_div;
   } stat_type;

   localparam logic signed [63:0] QMAX = 64'sd2147483647;
   localparam logic signed [63:0] QMIN = -64'sd2147483648;
endpackage
`default_nettype wire

@@ rtl/tsa_if.sv @@
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing.
`default_nettype none
interface tsa_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/tsa_ctrl.sv @@
// Controller state machine: sequences load, accumulate, divide and output.
// Depends on tsa_pkg.
`default_nettype none
module tsa_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   output logic                   out_valid,
   input  wire logic              out_ready,
   input  wire tsa_pkg::stat_type stat,
   output tsa_pkg::cmd_type       cmd
);
   import tsa_pkg::*;
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      in_ready  = 1'b0;
      out_valid = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cmd.load = 1'b1;
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            // always pass through S_MAC so the divider sees the settled accumulator
            cmd.mac_start = 1'b1;
            state_in = S_MAC;
         end
         S_MAC: begin
            if (stat.mac_done) begin
               if (stat.need_div) begin
                  cmd.div_start = 1'b1;
                  state_in = S_DIV;
               end else state_in = S_FINISH;
            end else cmd.mac_step = 1'b1;
         end
         S_DIV: begin
            if (stat.div_done) state_in = S_FINISH;
            else cmd.div_step = 1'b1;
         end
         S_FINISH: begin
            cmd.finish = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            out_valid = 1'b1;
            if (out_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end
endmodule
`default_nettype wire

@@ rtl/tsa_dp.sv @@
// Datapath: coefficient stores, multiply-accumulate, scale unit, restoring divider.
// Depends on tsa_pkg and tsa_scale.
`default_nettype none
module tsa_dp #(
   parameter int unsigned MAX_TERMS = 32
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire tsa_pkg::cmd_type             cmd,
   output tsa_pkg::stat_type                 stat,
   input  wire logic [tsa_pkg::INDEX_W-1:0]  degree,
   input  wire logic [2:0]                   action,
   input  wire logic signed [31:0]           u_coef,
   input  wire logic signed [31:0]           v_coef,
   input  wire logic signed [31:0]           scalar,
   output logic signed [31:0]                r_coef,
   output logic [tsa_pkg::INDEX_W-1:0]       term_index,
   output logic                              last,
   output logic [1:0]                        status
);
   import tsa_pkg::*;
   localparam int unsigned AW = $clog2(MAX_TERMS);
   localparam int unsigned PW = AW + 1;

   logic signed [31:0] u_mem [MAX_TERMS];
   logic signed [31:0] v_mem [MAX_TERMS];
   logic signed [31:0] q_mem [MAX_TERMS];

   logic [PW-1:0]      pos_ff;
   logic [AW-1:0]      n_ff;
   op_type             op_ff;
   logic signed [31:0] u_ff, v_ff, s_ff, v0_ff;
   logic [AW-1:0]      k_ff;
   logic               k_act_ff;   // product pipeline has a live term
   logic               rd_vld_ff, prod_vld_ff;
   logic signed [31:0] a_rd_ff, b_rd_ff;
   logic signed [63:0] prod_ff;
   logic signed [63:0] acc_ff;
   logic [63:0]        rem_ff, quo_ff, den_ff;
   logic [6:0]         dcnt_ff;
   logic               dneg_ff, dsat_ff;

   logic [AW-1:0] n_cur;
   logic [AW-1:0] k_top;
   logic          is_div;

   logic signed [63:0] sum_w;
   logic signed [31:0] r_next;
   logic [1:0]         st_next;
   logic               last_next;

   logic signed [63:0] scl_prod, scl_q;

   assign n_cur  = (pos_ff >= PW'(MAX_TERMS)) ? '0 : pos_ff[AW-1:0];
   assign is_div = (op_ff == OP_DIV);
   // multiply sums k=0..n, divide k=0..n-1
   assign k_top  = is_div ? n_ff - AW'(1) : n_ff;

   assign stat.need_mac = ((op_ff == OP_MUL) || (is_div && n_ff != '0 && v0_ff != 0));
   assign stat.need_div = is_div && (v0_ff != 0);
   assign stat.mac_done = !k_act_ff && !rd_vld_ff && !prod_vld_ff;
   assign stat.div_done = (dcnt_ff == '0);

   // stores and item capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         u_mem[n_cur] <= u_coef;
         v_mem[n_cur] <= v_coef;
         u_ff <= u_coef;
         v_ff <= v_coef;
         s_ff <= scalar;
         n_ff <= n_cur;
         if (n_cur == '0) v0_ff <= v_coef;
      end
      if (cmd.finish && is_div) q_mem[n_ff] <= r_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         op_ff  <= OP_ADD;
      end else if (cmd.load) begin
         if (n_cur == '0) op_ff <= op_type'(action);
      end else if (cmd.finish) begin
         pos_ff <= last_next ? '0 : PW'(n_ff) + PW'(1);
      end
   end

   // term read: one store word pair per cycle, registered
   always_ff @(posedge clock) begin
      if (reset) begin
         k_act_ff <= 1'b0; rd_vld_ff <= 1'b0; prod_vld_ff <= 1'b0;
      end else begin
         if (cmd.mac_start) begin
            k_act_ff <= stat.need_mac;
            k_ff <= '0;
         end else if (cmd.mac_step && k_act_ff) begin
            k_ff <= k_ff + AW'(1);
            if (k_ff == k_top) k_act_ff <= 1'b0;
         end
         rd_vld_ff   <= cmd.mac_step && k_act_ff;
         prod_vld_ff <= rd_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_rd_ff <= is_div ? q_mem[k_ff] : u_mem[k_ff];
      b_rd_ff <= v_mem[n_ff - k_ff];
      prod_ff <= 64'(a_rd_ff) * 64'(b_rd_ff);
   end

   logic signed [63:0] prod_q;
   assign prod_q = (prod_ff + 64'sd8388608) >>> 24;

   always_ff @(posedge clock) begin
      if (cmd.mac_start) acc_ff <= is_div ? 64'(u_ff) : '0;
      else if (prod_vld_ff) acc_ff <= is_div ? acc_ff - prod_q : acc_ff + prod_q;
   end

   // scale product, settled well before the finish step
   tsa_scale u_scale (
      .clock,
      .a(u_ff),
      .b(s_ff),
      .prod_ff(scl_prod)
   );
   assign scl_q = (scl_prod + 64'sd8388608) >>> 24;

   // restoring divider: one quotient bit per cycle, 64 quotient bits
   logic [63:0] an_w, ad_w, rem_sh;
   assign an_w = acc_ff[63] ? 64'(-acc_ff) : 64'(acc_ff);
   assign ad_w = v0_ff[31] ? 64'(-64'(v0_ff)) : 64'(unsigned'(v0_ff));
   assign rem_sh = {rem_ff[62:0], quo_ff[63]};

   always_ff @(posedge clock) begin
      if (reset) dcnt_ff <= '0;
      else if (cmd.div_start) begin
         dcnt_ff <= 7'd64;
         rem_ff  <= '0;
         quo_ff  <= an_w << 24;
         den_ff  <= ad_w;
         dneg_ff <= acc_ff[63] ^ v0_ff[31];
         dsat_ff <= an_w > 64'd274877906944;
      end else if (cmd.div_step) begin
         dcnt_ff <= dcnt_ff - 7'd1;
         if (rem_sh >= den_ff) begin
            rem_ff <= rem_sh - den_ff;
            quo_ff <= {quo_ff[62:0], 1'b1};
         end else begin
            rem_ff <= rem_sh;
            quo_ff <= {quo_ff[62:0], 1'b0};
         end
      end
   end

   // result
   assign last_next = (n_ff >= degree) || (n_ff == AW'(MAX_TERMS - 1));

   always_comb begin
      sum_w   = '0;
      r_next  = '0;
      st_next = ST_OK;
      unique case (op_ff)
         OP_ADD:  sum_w = 64'(u_ff) + 64'(v_ff);
         OP_SUB:  sum_w = 64'(u_ff) - 64'(v_ff);
         OP_MUL:  sum_w = acc_ff;
         OP_SCL:  sum_w = scl_q;
         OP_ADDS: sum_w = (n_ff == '0) ? 64'(u_ff) + 64'(s_ff) : 64'(u_ff);
         default: sum_w = '0;
      endcase
      if (is_div) begin
         if (v0_ff == 0) st_next = ST_DIVZ;
         else if (dsat_ff) begin
            st_next = ST_SAT;
            r_next = dneg_ff ? 32'sh80000000 : 32'sh7fffffff;
         end else if (dneg_ff) begin
            if (quo_ff > 64'h80000000) begin
               st_next = ST_SAT; r_next = 32'sh80000000;
            end else r_next = 32'(-quo_ff);
         end else if (quo_ff > 64'h7fffffff) begin
            st_next = ST_SAT; r_next = 32'sh7fffffff;
         end else r_next = quo_ff[31:0];
      end else if (sum_w > QMAX) begin
         st_next = ST_SAT; r_next = 32'sh7fffffff;
      end else if (sum_w < QMIN) begin
         st_next = ST_SAT; r_next = 32'sh80000000;
      end else r_next = sum_w[31:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         r_coef     <= r_next;
         term_index <= INDEX_W'(n_ff);
         last       <= last_next;
         status     <= st_next;
      end
   end
endmodule
`default_nettype wire

@@ rtl/tsa_scale.sv @@
// Scale unit: registered Q16.48 product of a Q8.24 coefficient and a Q8.24 scalar.
// Depends on nothing.
`default_nettype none
module tsa_scale (
   input  wire logic               clock,
   input  wire logic signed [31:0] a,
   input  wire logic signed [31:0] b,
   output logic signed [63:0]      prod_ff
);
   always_ff @(posedge clock) prod_ff <= 64'(a) * 64'(b);
endmodule
`default_nettype wire

@@ rtl/taylor_series_arithmetic_top.sv @@
// Taylor series arithmetic top level: controller plus datapath.
// Sequence per item: load, accumulate, divide (divide only, bit-serial), finish and
// output; multiply and divide form one product per cycle while they accumulate.
// One item at a time; a result holds until taken and the next transfer is accepted
// in the cycle after it.
// Reset: synchronous; series position and operation clear, degree returns to 5.
`default_nettype none
module taylor_series_arithmetic_top #(
   parameter int unsigned MAX_TERMS = 32
) (
   input wire logic clock,
   input wire logic reset,
   tsa_if.sink      req,
   tsa_if.source    rsp,
   tsa_if.sink      csr
);
   import tsa_pkg::*;
   cmd_type  cmd;
   stat_type stat;
   logic [INDEX_W-1:0] degree_ff;

   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) degree_ff <= INDEX_W'(5);
      else if (csr.valid) degree_ff <= csr.data.degree;
   end

   tsa_ctrl u_ctrl (
      .clock, .reset,
      .in_valid(req.valid), .in_ready(req.ready),
      .out_valid(rsp.valid), .out_ready(rsp.ready),
      .stat, .cmd
   );

   tsa_dp #(.MAX_TERMS(MAX_TERMS)) u_dp (
      .clock, .reset, .cmd, .stat,
      .degree(degree_ff),
      .action(req.data.action), .u_coef(req.data.u_coef),
      .v_coef(req.data.v_coef), .scalar(req.data.scalar),
      .r_coef(rsp.data.r_coef), .term_index(rsp.data.term_index),
      .last(rsp.data.last), .status(rsp.data.status)
   );

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      !(cmd.load && (cmd.finish || cmd.mac_step || cmd.div_step)))
      else $error("overlapping commands");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !req.ready)
      else $error("input taken while result pending");
   a_finish_out: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp.valid)
      else $error("finished result not presented");
endmodule
`default_nettype wire
